>>> rtl/btpd_pkg.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer package
// Shared constants, phase codes and beat types of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package btpd_pkg;

   localparam int BLOCK_SHIFT  = 6;
   localparam int MAX_TRANSFER = 32768;
   localparam int LEN_W        = 16;
   localparam int CNT_W        = 32;

   typedef logic [LEN_W-1:0]       len_type;
   typedef logic [BLOCK_SHIFT-1:0] pad_type;
   typedef logic [CNT_W-1:0]       cnt_type;

   localparam len_type MAX_TRANSFER_LEN = len_type'(MAX_TRANSFER);
   localparam len_type POS_SATURATED    = {LEN_W{1'b1}};

   typedef enum logic [1:0] {
      PH_HDR_LO  = 2'd0,
      PH_HDR_HI  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_PAD     = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_transfer;
      logic       last_of_transfer;
      len_type    transfer_length;
      logic       transfer_failed;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       packet_first;
      logic       packet_last;
      logic       length_error;
      cnt_type    packets_received;
      cnt_type    bytes_received;
      cnt_type    length_errors;
   } rsp_beat_type;

   typedef struct packed {
      logic         has_result;
      rsp_beat_type beat;
   } parse_result_type;

endpackage

`default_nettype wire

>>> rtl/btpd_ifs.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer channels
// Valid/ready channel interfaces for the request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface btpd_req_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           data_byte;
   logic                 first_of_transfer;
   logic                 last_of_transfer;
   btpd_pkg::len_type    transfer_length;
   logic                 transfer_failed;

   modport source (
      output valid, data_byte, first_of_transfer, last_of_transfer,
             transfer_length, transfer_failed,
      input  ready
   );
   modport sink (
      input  valid, data_byte, first_of_transfer, last_of_transfer,
             transfer_length, transfer_failed,
      output ready
   );
   modport monitor (
      input valid, ready, data_byte, first_of_transfer, last_of_transfer,
            transfer_length, transfer_failed
   );
endinterface

interface btpd_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           payload_byte;
   logic                 byte_valid;
   logic                 packet_first;
   logic                 packet_last;
   logic                 length_error;
   btpd_pkg::cnt_type    packets_received;
   btpd_pkg::cnt_type    bytes_received;
   btpd_pkg::cnt_type    length_errors;

   modport source (
      output valid, payload_byte, byte_valid, packet_first, packet_last,
             length_error, packets_received, bytes_received, length_errors,
      input  ready
   );
   modport sink (
      input  valid, payload_byte, byte_valid, packet_first, packet_last,
             length_error, packets_received, bytes_received, length_errors,
      output ready
   );
   modport monitor (
      input valid, ready, payload_byte, byte_valid, packet_first, packet_last,
            length_error, packets_received, bytes_received, length_errors
   );
endinterface

`default_nettype wire

>>> rtl/btpd_parser.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer parser
// Holds the running parse state and counters and decodes one beat per step.
// ----------------------------------------------------------------------------
`default_nettype none

module btpd_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       single_packet_mode,
   input  wire btpd_pkg::req_beat_type     item,
   output btpd_pkg::parse_result_type      result
);

   btpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          header_low_ff, header_low_in;
   btpd_pkg::len_type   packet_length_ff, packet_length_in;
   btpd_pkg::len_type   payload_left_ff, payload_left_in;
   btpd_pkg::len_type   position_ff, position_in;
   btpd_pkg::pad_type   pad_left_ff, pad_left_in;
   logic                discard_ff, discard_in;
   btpd_pkg::cnt_type   packet_count_ff, packet_count_in;
   btpd_pkg::cnt_type   byte_count_ff, byte_count_in;
   btpd_pkg::cnt_type   error_count_ff, error_count_in;

   always_comb begin
      btpd_pkg::len_type pos;
      btpd_pkg::len_type pos_next;
      btpd_pkg::len_type eff;
      btpd_pkg::len_type remaining;
      btpd_pkg::len_type hdr_len;
      btpd_pkg::len_type len_plus1;
      btpd_pkg::len_type left;
      btpd_pkg::pad_type pad;
      logic              emit;
      logic              valid_b;
      logic              pkt_first;
      logic              pkt_last;
      logic              err;
      logic [7:0]        out_byte;

      phase_in         = item.first_of_transfer ? btpd_pkg::PH_HDR_LO : phase_ff;
      pad_left_in      = item.first_of_transfer ? '0 : pad_left_ff;
      payload_left_in  = item.first_of_transfer ? '0 : payload_left_ff;
      discard_in       = item.first_of_transfer ? 1'b0 : discard_ff;
      pos              = item.first_of_transfer ? '0 : position_ff;
      header_low_in    = header_low_ff;
      packet_length_in = packet_length_ff;
      pos_next         = (pos != btpd_pkg::POS_SATURATED) ? pos + 1'b1 : pos;
      position_in      = pos_next;
      eff              = (item.transfer_length < btpd_pkg::MAX_TRANSFER_LEN)
                         ? item.transfer_length : btpd_pkg::MAX_TRANSFER_LEN;
      remaining        = eff - pos_next;
      hdr_len          = {item.data_byte, header_low_ff};
      len_plus1        = '0;
      left             = '0;
      pad              = '0;
      emit             = 1'b0;
      valid_b          = 1'b0;
      pkt_first        = 1'b0;
      pkt_last         = 1'b0;
      err              = 1'b0;
      out_byte         = '0;

      if (item.transfer_failed) begin
         discard_in = 1'b1;
      end else if (discard_in) begin
         discard_in = 1'b1;
      end else if (single_packet_mode) begin
         if (eff == '0) begin
            if (pos == '0) begin
               emit      = 1'b1;
               pkt_first = 1'b1;
               pkt_last  = 1'b1;
            end
         end else if (pos < eff) begin
            emit      = 1'b1;
            valid_b   = 1'b1;
            out_byte  = item.data_byte;
            pkt_first = (pos == '0);
            pkt_last  = (pos_next == eff) || item.last_of_transfer;
         end
      end else if (pos < eff) begin
         case (phase_in)
            btpd_pkg::PH_HDR_LO: begin
               header_low_in = item.data_byte;
               phase_in      = btpd_pkg::PH_HDR_HI;
            end
            btpd_pkg::PH_HDR_HI: begin
               packet_length_in = hdr_len;
               if (hdr_len > remaining) begin
                  emit       = 1'b1;
                  err        = 1'b1;
                  discard_in = 1'b1;
               end else if (hdr_len == '0) begin
                  emit        = 1'b1;
                  pkt_first   = 1'b1;
                  pkt_last    = 1'b1;
                  len_plus1   = hdr_len + 1'b1;
                  pad         = ~len_plus1[btpd_pkg::BLOCK_SHIFT-1:0];
                  pad_left_in = pad;
                  phase_in    = (pad != '0) ? btpd_pkg::PH_PAD : btpd_pkg::PH_HDR_LO;
               end else begin
                  payload_left_in = hdr_len;
                  phase_in        = btpd_pkg::PH_PAYLOAD;
               end
            end
            btpd_pkg::PH_PAYLOAD: begin
               emit            = 1'b1;
               valid_b         = 1'b1;
               out_byte        = item.data_byte;
               pkt_first       = (payload_left_in == packet_length_ff);
               pkt_last        = (payload_left_in <= 16'd1) || item.last_of_transfer;
               left            = (payload_left_in != '0) ? payload_left_in - 1'b1 : '0;
               payload_left_in = left;
               if (left == '0) begin
                  len_plus1   = packet_length_ff + 1'b1;
                  pad         = ~len_plus1[btpd_pkg::BLOCK_SHIFT-1:0];
                  pad_left_in = pad;
                  phase_in    = (pad != '0) ? btpd_pkg::PH_PAD : btpd_pkg::PH_HDR_LO;
               end
            end
            default: begin
               if (pad_left_in != '0) begin
                  pad_left_in = pad_left_in - 1'b1;
               end
               if (pad_left_in == '0) begin
                  phase_in = btpd_pkg::PH_HDR_LO;
               end
            end
         endcase
      end

      if (item.last_of_transfer) begin
         discard_in = 1'b1;
      end

      packet_count_in = packet_count_ff + btpd_pkg::cnt_type'(pkt_last);
      byte_count_in   = byte_count_ff + btpd_pkg::cnt_type'(valid_b);
      error_count_in  = error_count_ff + btpd_pkg::cnt_type'(err);

      result.has_result            = emit;
      result.beat.payload_byte     = out_byte;
      result.beat.byte_valid       = valid_b;
      result.beat.packet_first     = pkt_first;
      result.beat.packet_last      = pkt_last;
      result.beat.length_error     = err;
      result.beat.packets_received = packet_count_in;
      result.beat.bytes_received   = byte_count_in;
      result.beat.length_errors    = error_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= btpd_pkg::PH_HDR_LO;
         header_low_ff    <= '0;
         packet_length_ff <= '0;
         payload_left_ff  <= '0;
         position_ff      <= '0;
         pad_left_ff      <= '0;
         discard_ff       <= 1'b0;
         packet_count_ff  <= '0;
         byte_count_ff    <= '0;
         error_count_ff   <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         header_low_ff    <= header_low_in;
         packet_length_ff <= packet_length_in;
         payload_left_ff  <= payload_left_in;
         position_ff      <= position_in;
         pad_left_ff      <= pad_left_in;
         discard_ff       <= discard_in;
         packet_count_ff  <= packet_count_in;
         byte_count_ff    <= byte_count_in;
         error_count_ff   <= error_count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bulk_transfer_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer core
// Splits received bulk transfer bytes into packets and keeps counters.
// ----------------------------------------------------------------------------
// Request beats carry one byte of a received transfer with its length, failed
// flag and first/last marks. Response beats carry one payload byte with packet
// start and end marks, or an empty-packet or length-error marker, together with
// the running packet, byte and error counters after that beat.
// The csr port writes the single-packet mode bit; write it only while the
// block is idle.
// A request beat is held in the input register and is decoded into the
// output register, from which its response is offered. Beats that cause no
// response are consumed silently. One beat is accepted per cycle for as long
// as responses are taken. When the receiver stalls, the output register holds
// its beat; the input register still takes a request beat while it is empty,
// and ready drops once it is full.
// Synchronous reset clears the mode bit, the parse state and the counters,
// and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bulk_transfer_packet_deframer_core (
   input  wire logic   clock,
   input  wire logic   reset,
   btpd_req_if.sink    req_if,
   btpd_rsp_if.source  rsp_if,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);

   logic                         mode_ff;
   logic                         in_valid_ff;
   btpd_pkg::req_beat_type       in_beat_ff;
   logic                         out_valid_ff;
   btpd_pkg::rsp_beat_type       out_beat_ff;
   logic                         advance;
   btpd_pkg::parse_result_type   result;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   btpd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .step               (advance),
      .single_packet_mode (mode_ff),
      .item               (in_beat_ff),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_beat_ff.data_byte         <= req_if.data_byte;
         in_beat_ff.first_of_transfer <= req_if.first_of_transfer;
         in_beat_ff.last_of_transfer  <= req_if.last_of_transfer;
         in_beat_ff.transfer_length   <= req_if.transfer_length;
         in_beat_ff.transfer_failed   <= req_if.transfer_failed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.has_result;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.has_result) begin
         out_beat_ff <= result.beat;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.payload_byte     = out_beat_ff.payload_byte;
   assign rsp_if.byte_valid       = out_beat_ff.byte_valid;
   assign rsp_if.packet_first     = out_beat_ff.packet_first;
   assign rsp_if.packet_last      = out_beat_ff.packet_last;
   assign rsp_if.length_error     = out_beat_ff.length_error;
   assign rsp_if.packets_received = out_beat_ff.packets_received;
   assign rsp_if.bytes_received   = out_beat_ff.bytes_received;
   assign rsp_if.length_errors    = out_beat_ff.length_errors;

endmodule

`default_nettype wire

>>> rtl/btpd_checker.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer checker
// Port-level assertions on the response channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module btpd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [7:0]        rsp_payload_byte,
   input wire logic              rsp_byte_valid,
   input wire logic              rsp_packet_first,
   input wire logic              rsp_packet_last,
   input wire logic              rsp_length_error,
   input wire btpd_pkg::cnt_type rsp_packets_received,
   input wire btpd_pkg::cnt_type rsp_bytes_received,
   input wire btpd_pkg::cnt_type rsp_length_errors
);

   logic rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_byte_valid)
          && $stable(rsp_bytes_received) && $stable(rsp_packets_received)))
      else $error("response beat changed while stalled");

   a_error_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length_error) |->
         (!rsp_byte_valid && !rsp_packet_first && !rsp_packet_last
          && rsp_payload_byte == 8'd0))
      else $error("length error beat carries packet data");

   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_take ##1 rsp_take) |->
         (rsp_bytes_received ==
          $past(rsp_bytes_received) + btpd_pkg::cnt_type'(rsp_byte_valid)))
      else $error("byte counter does not follow delivered bytes");

   a_error_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_take ##1 rsp_take) |->
         (rsp_length_errors ==
          $past(rsp_length_errors) + btpd_pkg::cnt_type'(rsp_length_error)))
      else $error("error counter does not follow length error beats");

endmodule

bind bulk_transfer_packet_deframer_core btpd_checker u_btpd_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_payload_byte     (rsp_if.payload_byte),
   .rsp_byte_valid       (rsp_if.byte_valid),
   .rsp_packet_first     (rsp_if.packet_first),
   .rsp_packet_last      (rsp_if.packet_last),
   .rsp_length_error     (rsp_if.length_error),
   .rsp_packets_received (rsp_if.packets_received),
   .rsp_bytes_received   (rsp_if.bytes_received),
   .rsp_length_errors    (rsp_if.length_errors)
);

`default_nettype wire

>>> bench/btpd_deframe_checker.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer checker
// Watches the request, response and csr ports of the deframer, works out the
// response beats that every accepted request beat must produce, and compares
// each accepted response beat with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module btpd_deframe_checker
   import btpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   btpd_req_if.monitor req_mon,
   btpd_rsp_if.monitor rsp_mon,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          mismatch_count,
   output int          beats_in_flight,
   output int          beats_compared
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic         single_mode;
   phase_type    phase;
   logic [7:0]   header_lo;
   len_type      pkt_len;
   len_type      payload_left;
   len_type      position;
   pad_type      pad_left;
   logic         discard;
   cnt_type      pkt_cnt;
   cnt_type      byte_cnt;
   cnt_type      err_cnt;

   rsp_beat_type deframed_beats[$];
   req_beat_type seen_req;
   rsp_beat_type seen_rsp;
   rsp_beat_type made;
   rsp_beat_type oldest;
   int           errors = 0;
   int           compared = 0;

   function automatic void end_payload();
      int unsigned stride;
      stride = (((int'(pkt_len) + 1) >> BLOCK_SHIFT) + 1) << BLOCK_SHIFT;
      pad_left = pad_type'(stride - 2 - int'(pkt_len));
      phase = (pad_left != '0) ? PH_PAD : PH_HDR_LO;
   endfunction

   function automatic bit deframe_byte(input req_beat_type b, output rsp_beat_type r);
      int unsigned eff;
      int unsigned p;
      int unsigned remaining;
      bit          hit;
      bit          at_end;
      eff = (b.transfer_length < MAX_TRANSFER_LEN) ? b.transfer_length : MAX_TRANSFER_LEN;
      r = '0;
      hit = 1'b0;
      if (b.first_of_transfer) begin
         position = '0;
         phase = PH_HDR_LO;
         pad_left = '0;
         payload_left = '0;
         discard = 1'b0;
      end
      p = position;
      if (position != POS_SATURATED) begin
         position = position + 1'b1;
      end
      if (b.transfer_failed) begin
         discard = 1'b1;
      end else if (!discard) begin
         if (single_mode) begin
            if (eff == 0) begin
               if (p == 0) begin
                  pkt_cnt++;
                  r.packet_first = 1'b1;
                  r.packet_last = 1'b1;
                  hit = 1'b1;
               end
            end else if (p < eff) begin
               at_end = (p + 1 == eff) || b.last_of_transfer;
               byte_cnt++;
               if (at_end) begin
                  pkt_cnt++;
               end
               r.payload_byte = b.data_byte;
               r.byte_valid = 1'b1;
               r.packet_first = (p == 0);
               r.packet_last = at_end;
               hit = 1'b1;
            end
         end else if (p < eff) begin
            case (phase)
               PH_HDR_LO: begin
                  header_lo = b.data_byte;
                  phase = PH_HDR_HI;
               end
               PH_HDR_HI: begin
                  remaining = eff - (p + 1);
                  pkt_len = {b.data_byte, header_lo};
                  if (pkt_len > remaining) begin
                     err_cnt++;
                     discard = 1'b1;
                     r.length_error = 1'b1;
                     hit = 1'b1;
                  end else if (pkt_len == 0) begin
                     pkt_cnt++;
                     r.packet_first = 1'b1;
                     r.packet_last = 1'b1;
                     hit = 1'b1;
                     end_payload();
                  end else begin
                     payload_left = pkt_len;
                     phase = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  at_end = (payload_left <= 1) || b.last_of_transfer;
                  byte_cnt++;
                  if (at_end) begin
                     pkt_cnt++;
                  end
                  r.payload_byte = b.data_byte;
                  r.byte_valid = 1'b1;
                  r.packet_first = (payload_left == pkt_len);
                  r.packet_last = at_end;
                  hit = 1'b1;
                  if (payload_left != 0) begin
                     payload_left = payload_left - 1'b1;
                  end
                  if (payload_left == 0) begin
                     end_payload();
                  end
               end
               default: begin
                  if (pad_left != 0) begin
                     pad_left = pad_left - 1'b1;
                  end
                  if (pad_left == 0) begin
                     phase = PH_HDR_LO;
                  end
               end
            endcase
         end
      end
      if (hit) begin
         r.packets_received = pkt_cnt;
         r.bytes_received = byte_cnt;
         r.length_errors = err_cnt;
      end
      if (b.last_of_transfer) begin
         discard = 1'b1;
      end
      return hit;
   endfunction

   function automatic string beat_text(input rsp_beat_type r);
      return $sformatf("byte=%02h valid=%b first=%b last=%b lerr=%b pkts=%0d bytes=%0d errs=%0d",
                       r.payload_byte, r.byte_valid, r.packet_first, r.packet_last,
                       r.length_error, r.packets_received, r.bytes_received,
                       r.length_errors);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         single_mode = 1'b0;
         phase = PH_HDR_LO;
         header_lo = '0;
         pkt_len = '0;
         payload_left = '0;
         position = '0;
         pad_left = '0;
         discard = 1'b0;
         pkt_cnt = '0;
         byte_cnt = '0;
         err_cnt = '0;
         deframed_beats.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            seen_req.data_byte = req_mon.data_byte;
            seen_req.first_of_transfer = req_mon.first_of_transfer;
            seen_req.last_of_transfer = req_mon.last_of_transfer;
            seen_req.transfer_length = req_mon.transfer_length;
            seen_req.transfer_failed = req_mon.transfer_failed;
            if (deframe_byte(seen_req, made)) begin
               deframed_beats.push_back(made);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_rsp.payload_byte = rsp_mon.payload_byte;
            seen_rsp.byte_valid = rsp_mon.byte_valid;
            seen_rsp.packet_first = rsp_mon.packet_first;
            seen_rsp.packet_last = rsp_mon.packet_last;
            seen_rsp.length_error = rsp_mon.length_error;
            seen_rsp.packets_received = rsp_mon.packets_received;
            seen_rsp.bytes_received = rsp_mon.bytes_received;
            seen_rsp.length_errors = rsp_mon.length_errors;
            if (deframed_beats.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: response beat with none outstanding: %s", $realtime,
                           beat_text(seen_rsp));
               end
            end else begin
               oldest = deframed_beats.pop_front();
               compared++;
               if (oldest.payload_byte !== seen_rsp.payload_byte ||
                   oldest.byte_valid !== seen_rsp.byte_valid ||
                   oldest.packet_first !== seen_rsp.packet_first ||
                   oldest.packet_last !== seen_rsp.packet_last ||
                   oldest.length_error !== seen_rsp.length_error ||
                   oldest.packets_received !== seen_rsp.packets_received ||
                   oldest.bytes_received !== seen_rsp.bytes_received ||
                   oldest.length_errors !== seen_rsp.length_errors) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: response beat %0d differs", $realtime, compared);
                     $display("   expected %s", beat_text(oldest));
                     $display("   actual   %s", beat_text(seen_rsp));
                  end
               end
            end
         end
         if (csr_wr_en) begin
            single_mode = csr_wr_data;
         end
      end
      mismatch_count <= errors;
      beats_in_flight <= deframed_beats.size();
      beats_compared <= compared;
   end

endmodule

>>> bench/bulk_transfer_packet_deframer_core_tb.sv
// ----------------------------------------------------------------------------
// Bulk transfer packet deframer core testbench
// Drives received transfers into the deframer in framed and single-packet
// mode, first a few hand-built ones and then random ones with broken and
// noisy transfers mixed in, with random idle bursts on both channels and a
// long receiver stall. The checker beside the block judges every response.
// ----------------------------------------------------------------------------
module bulk_transfer_packet_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import btpd_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_BEATS = 1900;
   localparam int PHASES       = 8;
   localparam int TIME_LIMIT   = 8_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   btpd_req_if req_if();
   btpd_rsp_if rsp_if();

   int mismatch_count;
   int beats_in_flight;
   int beats_compared;

   int gap_pct = 0;
   int stall_pct = 0;
   bit hold_rsp = 1'b0;
   int beats_sent = 0;
   int transfers_sent = 0;
   int mode_writes = 0;

   req_beat_type transfer_beats[$];

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   bulk_transfer_packet_deframer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   btpd_deframe_checker deframe_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .beats_in_flight (beats_in_flight),
      .beats_compared  (beats_compared)
   );

   function automatic void push_beat(input logic [7:0] data, input bit first_mark,
                                     input bit last_mark, input len_type tlen,
                                     input bit failed);
      req_beat_type b;
      b.data_byte = data;
      b.first_of_transfer = first_mark;
      b.last_of_transfer = last_mark;
      b.transfer_length = tlen;
      b.transfer_failed = failed;
      transfer_beats.push_back(b);
   endfunction

   function automatic void shape_transfer(input logic [7:0] bytes[$], input bit framed,
                                          input int unsigned nominal);
      int unsigned kind;
      int unsigned tlen;
      int unsigned fail_at;
      int unsigned extra;
      bit          with_first;
      bit          with_last;
      bit          fail_all;
      with_first = 1'b1;
      with_last = 1'b1;
      fail_all = 1'b0;
      fail_at = bytes.size();
      tlen = nominal;
      extra = 0;
      kind = $urandom_range(0, 99);
      if (kind >= 60) begin
         if (kind < 66) begin
            tlen = $urandom_range(0, 65535);
         end else if (kind < 70) begin
            tlen = $urandom_range(0, nominal);
         end else if (kind < 76) begin
            if (framed && bytes.size() >= 2) begin
               bytes[1] = 8'($urandom);
            end
         end else if (kind < 80) begin
            if (bytes.size() > 2) begin
               repeat ($urandom_range(1, bytes.size() - 2)) void'(bytes.pop_back());
            end
         end else if (kind < 85) begin
            fail_all = 1'b1;
         end else if (kind < 88) begin
            fail_at = $urandom_range(0, bytes.size() - 1);
         end else if (kind < 91) begin
            with_last = 1'b0;
         end else if (kind < 94) begin
            extra = $urandom_range(1, 5);
         end else if (kind < 97) begin
            with_first = 1'b0;
         end else begin
            case ($urandom_range(0, 4))
               0: tlen = 0;
               1: tlen = 1;
               2: tlen = MAX_TRANSFER;
               3: tlen = MAX_TRANSFER + 1;
               default: tlen = 65535;
            endcase
         end
      end
      foreach (bytes[i]) begin
         push_beat(bytes[i], with_first && i == 0, with_last && i == bytes.size() - 1,
                   len_type'(tlen), fail_all || i == fail_at);
      end
      repeat (extra) begin
         push_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), len_type'($urandom), 1'b0);
      end
   endfunction

   function automatic void build_framed();
      logic [7:0]  bytes[$];
      int unsigned npk;
      int unsigned len;
      int unsigned pad;
      int unsigned pick;
      npk = $urandom_range(1, 3);
      for (int k = 0; k < npk; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            len = 0;
         end else if (pick < 80) begin
            len = $urandom_range(1, 16);
         end else if (pick < 95) begin
            len = $urandom_range(17, 62);
         end else begin
            len = $urandom_range(63, 70);
         end
         bytes.push_back(len[7:0]);
         bytes.push_back(len[15:8]);
         repeat (len) bytes.push_back(8'($urandom));
         pad = ((((len + 1) >> BLOCK_SHIFT) + 1) << BLOCK_SHIFT) - 2 - len;
         if (k + 1 < npk || $urandom_range(0, 1) == 1) begin
            repeat (pad) bytes.push_back(8'($urandom));
         end
      end
      shape_transfer(bytes, 1'b1, bytes.size());
   endfunction

   function automatic void build_single();
      logic [7:0]  bytes[$];
      int unsigned n;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
         shape_transfer(bytes, 1'b0, 0);
      end else begin
         n = $urandom_range(1, 40);
         repeat (n) bytes.push_back(8'($urandom));
         shape_transfer(bytes, 1'b0, n);
      end
   endfunction

   task automatic send_beat(input req_beat_type b);
      int gap;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b.data_byte;
      req_if.first_of_transfer <= b.first_of_transfer;
      req_if.last_of_transfer <= b.last_of_transfer;
      req_if.transfer_length <= b.transfer_length;
      req_if.transfer_failed <= b.transfer_failed;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      beats_sent++;
   endtask

   task automatic send_transfer();
      foreach (transfer_beats[i]) begin
         send_beat(transfer_beats[i]);
      end
      transfer_beats.delete();
      transfers_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (beats_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_writes++;
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int  target;
      bit  mode;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      req_if.first_of_transfer <= 1'b0;
      req_if.last_of_transfer <= 1'b0;
      req_if.transfer_length <= '0;
      req_if.transfer_failed <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(1'b0);
      // Empty packet, a three byte packet, a length error, a packet cut short
      // by the last mark, and a failed transfer.
      push_beat(8'h00, 1'b1, 1'b0, 16'd2, 1'b0);
      push_beat(8'h00, 1'b0, 1'b1, 16'd2, 1'b0);
      push_beat(8'h03, 1'b1, 1'b0, 16'd5, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0, 16'd5, 1'b0);
      push_beat(8'hAA, 1'b0, 1'b0, 16'd5, 1'b0);
      push_beat(8'hBB, 1'b0, 1'b0, 16'd5, 1'b0);
      push_beat(8'hCC, 1'b0, 1'b1, 16'd5, 1'b0);
      push_beat(8'hFF, 1'b1, 1'b0, 16'd3, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0, 16'd3, 1'b0);
      push_beat(8'h11, 1'b0, 1'b1, 16'd3, 1'b0);
      push_beat(8'h10, 1'b1, 1'b0, 16'hFFFF, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0, 16'hFFFF, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0, 16'hFFFF, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0, 16'hFFFF, 1'b0);
      push_beat(8'h80, 1'b0, 1'b1, 16'hFFFF, 1'b0);
      push_beat(8'h02, 1'b1, 1'b0, 16'd4, 1'b1);
      push_beat(8'h00, 1'b0, 1'b0, 16'd4, 1'b1);
      push_beat(8'h01, 1'b0, 1'b0, 16'd4, 1'b1);
      push_beat(8'h02, 1'b0, 1'b1, 16'd4, 1'b1);
      send_transfer();
      drain();

      // An empty single transfer, then one with a byte past its length.
      write_mode(1'b1);
      push_beat(8'h5A, 1'b1, 1'b1, 16'd0, 1'b0);
      push_beat(8'h00, 1'b1, 1'b0, 16'd3, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0, 16'd3, 1'b0);
      push_beat(8'h7E, 1'b0, 1'b0, 16'd3, 1'b0);
      push_beat(8'h81, 1'b0, 1'b1, 16'd3, 1'b0);
      send_transfer();
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         target = beats_sent + RANDOM_BEATS / PHASES;
         mode = ph[0];
         gap_pct = (ph == 0 || ph == PHASES - 1) ? 0 : $urandom_range(5, 25);
         stall_pct = (ph == 0 || ph == PHASES - 1) ? 0 : $urandom_range(3, 12);
         write_mode(mode);
         if (ph == 1) begin
            hold_rsp = 1'b1;
         end
         while (beats_sent < target) begin
            if (mode) begin
               build_single();
            end else begin
               build_framed();
            end
            send_transfer();
            if ($urandom_range(0, 9) == 0) begin
               drain();
            end
         end
         drain();
      end

      $display("Sent %0d request beats in %0d transfers over %0d mode writes.",
               beats_sent, transfers_sent, mode_writes);
      $display("Checked %0d response beats in framed and single-packet mode.", beats_compared);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #TIME_LIMIT;
      $display("Run timed out with %0d response beats outstanding.", beats_in_flight);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
